// ===== sv/ehc_pkg.sv =====
// ehc_pkg: constants shared by the equivalent humidity pipeline
`timescale 1ns / 1ps
package ehc_pkg;

  // default build parameters
  localparam int DEF_EXP_TABLE_ENTRIES = 256;
  localparam int DEF_FRACTION_BITS     = 16;

  // magnus coefficient 17.62*log2(e), Q32
  localparam longint unsigned MAGNUS_K_Q32 = 64'd109179299690;
  // ln(2), Q30
  localparam longint unsigned LN2_Q30      = 64'd744261118;
  // 216.7 * 6.112 scaled by 1e4
  localparam longint unsigned AH_COEF      = 64'd13244704;
  localparam int              AH_SCALE     = 10000;
  localparam int              AH_MAX       = 262143;
  localparam int              EQ_RH_MAX    = 100000;

  // temperature offsets in 0.01 degC
  localparam int DEW_OFFSET    = 24312;
  localparam int KELVIN_OFFSET = 27315;

  // exponent bias so the biased base-2 exponent stays positive
  localparam int EXP_BIAS = 64;

  // quotient bits kept for the equivalent rh division
  localparam int EQ_QW = 18;

endpackage

// ===== sv/equivalent_humidity_calc.sv =====
// equivalent_humidity_calc: magnus formula absolute and equivalent humidity pipeline
//
//   channel | signals                                              | dir
//   --------+------------------------------------------------------+-----
//   input   | in_valid in_ready internal_temp internal_rh          | in
//           | external_temp external_rh                            |
//   output  | out_valid out_ready external_abs_humidity            | out
//           | equivalent_rh rh_difference saturated                |
//
// One word per cycle sustained while out_ready is held high. The pipeline
// depth is set mostly by the four bit-per-stage dividers.
// rst clears all stage valid bits; no clearing pass is needed.
// Each stage takes a word when it is empty or its successor moves, so a
// stalled output fills the pipeline before in_ready drops.
`timescale 1ns / 1ps
module equivalent_humidity_calc #(
  parameter int EXP_TABLE_ENTRIES = ehc_pkg::DEF_EXP_TABLE_ENTRIES,
  parameter int FRACTION_BITS     = ehc_pkg::DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [14:0] internal_temp,
  input  logic        [13:0] internal_rh,
  input  logic signed [14:0] external_temp,
  input  logic        [13:0] external_rh,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [17:0] external_abs_humidity,
  output logic        [16:0] equivalent_rh,
  output logic signed [17:0] rh_difference,
  output logic               saturated
);
  import ehc_pkg::*;

  localparam int FB  = FRACTION_BITS;
  localparam int XW  = FB + 20;   // exponent dividend
  localparam int QY  = FB + 6;    // exponent magnitude
  localparam int YBW = FB + 7;    // biased exponent
  localparam int IW  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int PW  = FB + IW;
  localparam int MW  = FB + 2;    // mantissa
  localparam int NAW = FB + 40;
  localparam int NAS = FB + 42;
  localparam int NEW = FB + 32;
  localparam int DEW = FB + 18;
  localparam int QAW = FB + 17;
  localparam int NQW = 63;
  localparam int SWI = 60 + XW + 16;
  localparam int SWE = 60 + QY;
  localparam int SWQ = 14 + 3 + 16 + NAS + 29;
  localparam int SWA = 17 + 18 + 1 + 8;

  // 2^(i/N) table entry from a truncated series for exp(i*ln2/N)
  function automatic longint unsigned rom_entry(input int unsigned i);
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    longint unsigned u;
    longint unsigned s;
    longint unsigned tm;
    num = longint'(i) * LN2_Q30;
    q   = num / EXP_TABLE_ENTRIES;
    r   = num % EXP_TABLE_ENTRIES;
    u   = q + ((r >= EXP_TABLE_ENTRIES - r) ? 64'd1 : 64'd0);
    s   = 64'd1 << 30;
    tm  = 64'd1 << 30;
    tm = ((tm * u) >> 30) / 1;  s = s + tm;
    tm = ((tm * u) >> 30) / 2;  s = s + tm;
    tm = ((tm * u) >> 30) / 3;  s = s + tm;
    tm = ((tm * u) >> 30) / 4;  s = s + tm;
    tm = ((tm * u) >> 30) / 5;  s = s + tm;
    tm = ((tm * u) >> 30) / 6;  s = s + tm;
    tm = ((tm * u) >> 30) / 7;  s = s + tm;
    tm = ((tm * u) >> 30) / 8;  s = s + tm;
    tm = ((tm * u) >> 30) / 9;  s = s + tm;
    tm = ((tm * u) >> 30) / 10; s = s + tm;
    tm = ((tm * u) >> 30) / 11; s = s + tm;
    tm = ((tm * u) >> 30) / 12; s = s + tm;
    return (s + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
  endfunction

  // mantissa table
  logic [MW-1:0] rom [EXP_TABLE_ENTRIES+1];
  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_rom
    assign rom[g] = MW'(rom_entry(g));
  end

  // ---------------- stage 1: magnitude times magnus coefficient
  logic               v1, rdy1;
  logic        [51:0] s1_prod [2];
  logic        [15:0] s1_dsum [2];
  logic               s1_neg  [2];
  logic signed [14:0] s1_t    [2];
  logic        [13:0] s1_rh   [2];
  logic signed [14:0] in_t    [2];
  logic        [13:0] in_rh   [2];
  logic               rdy2;

  assign in_t[0]  = internal_temp;
  assign in_t[1]  = external_temp;
  assign in_rh[0] = internal_rh;
  assign in_rh[1] = external_rh;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [14:0] mag;
    if (rdy1 && in_valid) begin
      for (int l = 0; l < 2; l++) begin
        mag = in_t[l][14] ? 15'(-in_t[l]) : 15'(in_t[l]);
        s1_prod[l] <= 52'(MAGNUS_K_Q32) * 52'(mag);
        s1_dsum[l] <= 16'({{2{in_t[l][14]}}, in_t[l]} + 17'(DEW_OFFSET));
        s1_neg[l]  <= in_t[l][14];
        s1_t[l]    <= in_t[l];
        s1_rh[l]   <= in_rh[l];
      end
    end
  end

  // ---------------- stage 2: rounding offset folded into the dividend
  logic               v2;
  logic [XW-1:0]      s2_x    [2];
  logic [15:0]        s2_dsum [2];
  logic               s2_neg  [2];
  logic signed [14:0] s2_t    [2];
  logic [13:0]        s2_rh   [2];
  logic               di_in_ready;

  assign rdy2 = !v2 || di_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    logic [53:0] sum;
    if (rdy2 && v1) begin
      for (int l = 0; l < 2; l++) begin
        sum = {1'b0, s1_prod[l], 1'b0} + (54'(s1_dsum[l]) << (32 - FB));
        s2_x[l]    <= XW'(sum >> (33 - FB));
        s2_dsum[l] <= s1_dsum[l];
        s2_neg[l]  <= s1_neg[l];
        s2_t[l]    <= s1_t[l];
        s2_rh[l]   <= s1_rh[l];
      end
    end
  end

  // ---------------- exponent dividers, internal then external
  logic           di_out_valid, de_in_ready;
  logic [QY-1:0]  di_quo;
  logic [15:0]    di_rem, di_den;
  logic [SWI-1:0] di_side_in, di_side;
  logic [13:0]    di_rhi, di_rhe;
  logic [14:0]    di_ti, di_te;
  logic           di_ni, di_ne;
  logic [XW-1:0]  di_xe;
  logic [15:0]    di_de;

  assign di_side_in = {s2_rh[0], s2_rh[1], s2_t[0], s2_t[1], s2_neg[0], s2_neg[1],
                       s2_x[1], s2_dsum[1]};

  ehc_div #(.NW(XW), .DW(16), .QW(QY), .SW(SWI)) u_div_ti (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_ready(di_in_ready),
    .num(s2_x[0]), .den(s2_dsum[0]), .side(di_side_in),
    .out_valid(di_out_valid), .out_ready(de_in_ready),
    .quo(di_quo), .rem(di_rem), .den_out(di_den), .side_out(di_side)
  );

  assign {di_rhi, di_rhe, di_ti, di_te, di_ni, di_ne, di_xe, di_de} = di_side;

  logic           de_out_valid, rdy3;
  logic [QY-1:0]  de_quo;
  logic [15:0]    de_rem, de_den;
  logic [SWE-1:0] de_side_in, de_side;
  logic [13:0]    de_rhi, de_rhe;
  logic [14:0]    de_ti, de_te;
  logic           de_ni, de_ne;
  logic [QY-1:0]  de_ymi;

  assign de_side_in = {di_rhi, di_rhe, di_ti, di_te, di_ni, di_ne, di_quo};

  ehc_div #(.NW(XW), .DW(16), .QW(QY), .SW(SWE)) u_div_te (
    .clk(clk), .rst(rst),
    .in_valid(di_out_valid), .in_ready(de_in_ready),
    .num(di_xe), .den(di_de), .side(de_side_in),
    .out_valid(de_out_valid), .out_ready(rdy3),
    .quo(de_quo), .rem(de_rem), .den_out(de_den), .side_out(de_side)
  );

  assign {de_rhi, de_rhe, de_ti, de_te, de_ni, de_ne, de_ymi} = de_side;

  // ---------------- stage 3: biased exponent split into table position
  logic               v3, rdy4;
  logic [IW-1:0]      s3_idx [2];
  logic [FB-1:0]      s3_w   [2];
  logic signed [7:0]  s3_k   [2];
  logic signed [14:0] s3_t   [2];
  logic [13:0]        s3_rh  [2];
  logic [QY-1:0]      ym     [2];
  logic               yneg   [2];

  assign ym[0]   = de_ymi;
  assign ym[1]   = de_quo;
  assign yneg[0] = de_ni;
  assign yneg[1] = de_ne;
  assign rdy3    = !v3 || rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= de_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [YBW-1:0] yb;
    logic [PW-1:0]  p;
    if (rdy3 && de_out_valid) begin
      for (int l = 0; l < 2; l++) begin
        yb = (YBW'(EXP_BIAS) << FB) + (yneg[l] ? -YBW'(ym[l]) : YBW'(ym[l]));
        p  = PW'(yb[FB-1:0]) * PW'(EXP_TABLE_ENTRIES);
        s3_idx[l] <= p[PW-1:FB];
        s3_w[l]   <= p[FB-1:0];
        s3_k[l]   <= $signed({1'b0, yb[YBW-1:FB]}) - 8'sd64;
      end
      s3_t[0]  <= de_ti;
      s3_t[1]  <= de_te;
      s3_rh[0] <= de_rhi;
      s3_rh[1] <= de_rhe;
    end
  end

  // ---------------- stage 4: table reads
  logic               v4, rdy5;
  logic [MW-1:0]      s4_lo  [2];
  logic [MW-1:0]      s4_dlt [2];
  logic [FB-1:0]      s4_w   [2];
  logic signed [7:0]  s4_k   [2];
  logic signed [14:0] s4_t   [2];
  logic [13:0]        s4_rh  [2];

  assign rdy4 = !v4 || rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int l = 0; l < 2; l++) begin
        s4_lo[l]  <= rom[s3_idx[l]];
        s4_dlt[l] <= rom[s3_idx[l] + IW'(1)] - rom[s3_idx[l]];
        s4_w[l]   <= s3_w[l];
        s4_k[l]   <= s3_k[l];
        s4_t[l]   <= s3_t[l];
        s4_rh[l]  <= s3_rh[l];
      end
    end
  end

  // ---------------- stage 5: linear interpolation
  logic               v5, rdy6;
  logic [MW-1:0]      s5_m  [2];
  logic signed [7:0]  s5_k  [2];
  logic signed [14:0] s5_t  [2];
  logic [13:0]        s5_rh [2];

  assign rdy5 = !v5 || rdy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    logic [MW+FB-1:0] ip;
    if (rdy5 && v4) begin
      for (int l = 0; l < 2; l++) begin
        ip = (MW+FB)'(s4_dlt[l]) * (MW+FB)'(s4_w[l]) + ((MW+FB)'(1) << (FB - 1));
        s5_m[l]  <= s4_lo[l] + MW'(ip >> FB);
        s5_k[l]  <= s4_k[l];
        s5_t[l]  <= s4_t[l];
        s5_rh[l] <= s4_rh[l];
      end
    end
  end

  // ---------------- stage 6: scale factors and shift counts
  logic              v6, rdy7;
  logic [37:0]       s6_a1;
  logic [29:0]       s6_e1;
  logic [28:0]       s6_dah;
  logic [DEW-1:0]    s6_deq;
  logic signed [7:0] s6_sah, s6_seq;
  logic [MW-1:0]     s6_me;
  logic [13:0]       s6_rhi;

  assign rdy6 = !v6 || rdy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    logic [15:0] kofs_i;
    logic [15:0] kofs_e;
    if (rdy6 && v5) begin
      kofs_i = 16'({{2{s5_t[0][14]}}, s5_t[0]} + 17'(KELVIN_OFFSET));
      kofs_e = 16'({{2{s5_t[1][14]}}, s5_t[1]} + 17'(KELVIN_OFFSET));
      s6_a1  <= 38'(AH_COEF) * 38'(s5_rh[1]);
      s6_e1  <= 30'(s5_rh[1]) * 30'(kofs_i);
      s6_dah <= 29'(AH_SCALE) * 29'(kofs_e);
      s6_deq <= DEW'(kofs_e) * DEW'(s5_m[0]);
      s6_sah <= s5_k[1] - 8'(FB);
      s6_seq <= s5_k[1] - s5_k[0];
      s6_me  <= s5_m[1];
      s6_rhi <= s5_rh[0];
    end
  end

  // ---------------- stage 7: dividends
  logic              v7, rdy8;
  logic [NAW-1:0]    s7_nah;
  logic [NEW-1:0]    s7_neq;
  logic [28:0]       s7_dah;
  logic [DEW-1:0]    s7_deq;
  logic signed [7:0] s7_sah, s7_seq;
  logic [13:0]       s7_rhi;

  assign rdy7 = !v7 || rdy8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (rdy7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7 && v6) begin
      s7_nah <= NAW'(s6_a1) * NAW'(s6_me);
      s7_neq <= NEW'(s6_e1) * NEW'(s6_me);
      s7_dah <= s6_dah;
      s7_deq <= s6_deq;
      s7_sah <= s6_sah;
      s7_seq <= s6_seq;
      s7_rhi <= s6_rhi;
    end
  end

  // ---------------- stage 8: left shifts and overflow of the shifted dividend
  logic              v8, rdy9;
  logic [NAS-1:0]    s8_nah;
  logic [NQW-1:0]    s8_neq;
  logic              s8_zero, s8_covf;
  logic [28:0]       s8_dah;
  logic [DEW-1:0]    s8_deq;
  logic signed [7:0] s8_sah, s8_seq;
  logic [13:0]       s8_rhi;

  assign rdy8 = !v8 || rdy9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (rdy8) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    logic       zero;
    logic       up;
    logic       covf;
    logic [1:0] sha;
    if (rdy8 && v7) begin
      zero = (s7_neq == '0);
      up   = (s7_seq > 8'sd0);
      covf = !zero && up &&
             ((s7_seq >= 8'sd62) ||
              (NQW'(s7_neq) > ((NQW'(1) << 62) >> s7_seq[5:0])));
      sha  = (s7_sah > 8'sd0) ? s7_sah[1:0] : 2'd0;
      s8_nah  <= NAS'(s7_nah) << sha;
      s8_neq  <= (up && !covf) ? (NQW'(s7_neq) << s7_seq[5:0]) : NQW'(s7_neq);
      s8_zero <= zero;
      s8_covf <= covf;
      s8_dah  <= s7_dah;
      s8_deq  <= s7_deq;
      s8_sah  <= s7_sah;
      s8_seq  <= s7_seq;
      s8_rhi  <= s7_rhi;
    end
  end

  // ---------------- stage 9: quotient too wide for the rh divider
  logic              v9;
  logic [NQW-1:0]    s9_neq;
  logic [DEW-1:0]    s9_deq;
  logic [SWQ-1:0]    s9_side;
  logic              dq_in_ready;

  assign rdy9 = !v9 || dq_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (rdy9) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    logic povf;
    if (rdy9 && v8) begin
      povf = ((NQW - EQ_QW)'(s8_neq[NQW-1:EQ_QW]) >= (NQW - EQ_QW)'(s8_deq));
      s9_neq  <= s8_neq;
      s9_deq  <= s8_deq;
      s9_side <= {s8_rhi, s8_covf, povf, s8_zero, s8_seq, s8_sah, s8_nah, s8_dah};
    end
  end

  // ---------------- equivalent rh divider
  logic              dq_out_valid, rdy10;
  logic [EQ_QW-1:0]  dq_quo;
  logic [DEW-1:0]    dq_rem, dq_den;
  logic [SWQ-1:0]    dq_side;
  logic [13:0]       dq_rhi;
  logic              dq_covf, dq_povf, dq_zero;
  logic signed [7:0] dq_seq, dq_sah;
  logic [NAS-1:0]    dq_nah;
  logic [28:0]       dq_dah;

  ehc_div #(.NW(NQW), .DW(DEW), .QW(EQ_QW), .SW(SWQ)) u_div_eq (
    .clk(clk), .rst(rst),
    .in_valid(v9), .in_ready(dq_in_ready),
    .num(s9_neq), .den(s9_deq), .side(s9_side),
    .out_valid(dq_out_valid), .out_ready(rdy10),
    .quo(dq_quo), .rem(dq_rem), .den_out(dq_den), .side_out(dq_side)
  );

  assign {dq_rhi, dq_covf, dq_povf, dq_zero, dq_seq, dq_sah, dq_nah, dq_dah} = dq_side;

  // ---------------- stage 10: rh rounding, clipping and difference
  logic              v10;
  logic [NAS-1:0]    s10_nah;
  logic [28:0]       s10_dah;
  logic [SWA-1:0]    s10_side;
  logic              da_in_ready;

  assign rdy10 = !v10 || da_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (rdy10) begin
      v10 <= dq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [18:0] eqv;
    logic [19:0] sum;
    logic [7:0]  t;
    logic        sat;
    logic [16:0] eq;
    logic [17:0] diff;
    if (rdy10 && dq_out_valid) begin
      t   = 8'(-dq_seq);
      sum = 20'(dq_quo) + (20'd1 << (t[4:0] - 5'd1));
      if (dq_seq >= 8'sd0) begin
        eqv = 19'(dq_quo) + 19'({dq_rem, 1'b0} >= {1'b0, dq_den});
      end else if (t >= 8'd20) begin
        eqv = '0;
      end else begin
        eqv = 19'(sum >> t[4:0]);
      end
      sat  = !dq_zero && (dq_covf || dq_povf || (eqv > 19'(EQ_RH_MAX)));
      eq   = sat ? 17'(EQ_RH_MAX) : eqv[16:0];
      diff = {4'd0, dq_rhi} - {1'b0, eq};
      s10_side <= {eq, diff, sat, dq_sah};
      s10_nah  <= dq_nah;
      s10_dah  <= dq_dah;
    end
  end

  // ---------------- absolute humidity divider
  logic              da_out_valid, rdy11;
  logic [QAW-1:0]    da_quo;
  logic [28:0]       da_rem, da_den;
  logic [SWA-1:0]    da_side;
  logic [16:0]       da_eq;
  logic [17:0]       da_diff;
  logic              da_sat;
  logic signed [7:0] da_sah;

  ehc_div #(.NW(NAS), .DW(29), .QW(QAW), .SW(SWA)) u_div_ah (
    .clk(clk), .rst(rst),
    .in_valid(v10), .in_ready(da_in_ready),
    .num(s10_nah), .den(s10_dah), .side(s10_side),
    .out_valid(da_out_valid), .out_ready(rdy11),
    .quo(da_quo), .rem(da_rem), .den_out(da_den), .side_out(da_side)
  );

  assign {da_eq, da_diff, da_sat, da_sah} = da_side;

  // ---------------- stage 11: output word
  logic v11;

  assign rdy11     = !v11 || out_ready;
  assign out_valid = v11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (rdy11) begin
      v11 <= da_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [QAW:0] ah;
    logic [QAW:0] sum;
    logic [7:0]   t;
    if (rdy11 && da_out_valid) begin
      t   = 8'(-da_sah);
      sum = (QAW+1)'(da_quo) + ((QAW+1)'(1) << (t - 8'd1));
      if (da_sah >= 8'sd0) begin
        ah = (QAW+1)'(da_quo) + (QAW+1)'({da_rem, 1'b0} >= {1'b0, da_den});
      end else if (t > 8'(QAW)) begin
        ah = '0;
      end else begin
        ah = sum >> t;
      end
      external_abs_humidity <= (ah > (QAW+1)'(AH_MAX)) ? 18'(AH_MAX) : ah[17:0];
      equivalent_rh         <= da_eq;
      rh_difference         <= $signed(da_diff);
      saturated             <= da_sat;
    end
  end

endmodule

// ===== sv/ehc_div.sv =====
// ehc_div: pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ehc_div #(
  parameter int NW = 24,
  parameter int DW = 16,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den_out,
  output logic [SW-1:0] side_out
);

  // stage registers
  logic          vld    [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] wk_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  // stage inputs and next values
  logic          vin    [QW];
  logic [DW-1:0] rin    [QW];
  logic [QW-1:0] win    [QW];
  logic [DW-1:0] din    [QW];
  logic [SW-1:0] sin    [QW];
  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] wk_next  [QW];
  logic          rdy    [QW+1];

  // operand select per stage; top numerator bits seed the remainder
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        vin[j] = in_valid;
        rin[j] = DW'(num[NW-1:QW]);
        win[j] = num[QW-1:0];
        din[j] = den;
        sin[j] = side;
      end else begin
        vin[j] = vld[j-1];
        rin[j] = rem_r[j-1];
        win[j] = wk_r[j-1];
        din[j] = den_r[j-1];
        sin[j] = side_r[j-1];
      end
    end
  end

  // one trial subtract per stage
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    for (int j = 0; j < QW; j++) begin
      trial = {rin[j], win[j][QW-1]};
      ge    = (trial >= {1'b0, din[j]});
      rem_next[j] = ge ? DW'(trial - {1'b0, din[j]}) : trial[DW-1:0];
      wk_next[j]  = {win[j][QW-2:0], ge};
    end
  end

  // ready ripples back through empty stages
  always_comb begin
    rdy[QW] = out_ready;
    for (int j = QW - 1; j >= 0; j--) begin
      rdy[j] = !vld[j] || rdy[j+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= vin[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QW; j++) begin
      if (rdy[j] && vin[j]) begin
        rem_r[j]  <= rem_next[j];
        wk_r[j]   <= wk_next[j];
        den_r[j]  <= din[j];
        side_r[j] <= sin[j];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[QW-1];
  assign quo       = wk_r[QW-1];
  assign rem       = rem_r[QW-1];
  assign den_out   = den_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

// ===== verif/ehc_checker.sv =====
// ehc_checker: watches both channels, predicts each result word and compares it
`timescale 1ns / 1ps
module ehc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [14:0] internal_temp,
  input  logic        [13:0] internal_rh,
  input  logic signed [14:0] external_temp,
  input  logic        [13:0] external_rh,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [17:0] external_abs_humidity,
  input  logic        [16:0] equivalent_rh,
  input  logic signed [17:0] rh_difference,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending
);
  import ehc_pkg::*;

  localparam int N = DEF_EXP_TABLE_ENTRIES;
  localparam int F = DEF_FRACTION_BITS;

  typedef struct packed {
    logic [17:0] abs_hum;
    logic [16:0] eq_rh;
    logic [17:0] diff;
    logic        sat;
  } humidity_word_t;

  humidity_word_t humidity_q[$];
  longint unsigned pow2_rom[N+1];

  // round to nearest, ties up; t>0 means a rounded shift of the truncated num/den
  function automatic longint unsigned rnd_div(longint unsigned num, longint unsigned den,
                                              int t);
    longint unsigned q;
    longint unsigned r;
    q = num / den;
    r = num % den;
    if (t == 0) return q + ((r >= den - r) ? 64'd1 : 64'd0);
    if (t > 62) return 0;
    return (q + (64'd1 << (t - 1))) >> t;
  endfunction

  // 2^(i/N) by truncated series in Q30, rounded to QF
  function automatic longint unsigned pow2_entry(longint unsigned i);
    longint unsigned u;
    longint unsigned sum;
    longint unsigned term;
    u = rnd_div(i * LN2_Q30, N, 0);
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 30) / n;
      sum += term;
    end
    return rnd_div(sum, 1, 30 - F);
  endfunction

  initial begin
    for (int i = 0; i <= N; i++) pow2_rom[i] = pow2_entry(i);
  end

  // saturation vapour pressure exponent as mantissa and power of two
  function automatic longint unsigned magnus_exp(longint temp, output int k);
    longint unsigned mask;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned ym;
    longint yb;
    longint unsigned ub;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned w;
    mask = (64'd1 << F) - 1;
    mag = (temp < 0) ? longint'(-temp) : temp;
    den = longint'(DEW_OFFSET + temp) << (32 - F);
    ym = rnd_div(MAGNUS_K_Q32 * mag, den, 0);
    yb = (longint'(EXP_BIAS) << F) + ((temp < 0) ? -longint'(ym) : longint'(ym));
    ub = yb;
    pos = (ub & mask) * N;
    idx = pos >> F;
    w = pos & mask;
    k = int'(ub >> F) - EXP_BIAS;
    return pow2_rom[idx] + rnd_div((pow2_rom[idx+1] - pow2_rom[idx]) * w, 1, F);
  endfunction

  function automatic humidity_word_t predict_humidity(logic signed [14:0] ti_in,
      logic [13:0] rhi_in, logic signed [14:0] te_in, logic [13:0] rhe_in);
    humidity_word_t res;
    longint ti;
    longint te;
    longint unsigned rhi;
    longint unsigned rhe;
    longint unsigned mi;
    longint unsigned me;
    longint unsigned num;
    longint unsigned den;
    longint unsigned ah;
    longint unsigned eq;
    longint diff;
    int ki;
    int ke;
    int s;
    ti = ti_in;
    te = te_in;
    rhi = rhi_in;
    rhe = rhe_in;
    mi = magnus_exp(ti, ki);
    me = magnus_exp(te, ke);
    res.sat = 1'b0;

    // external absolute humidity
    num = AH_COEF * rhe * me;
    den = longint'(AH_SCALE) * longint'(KELVIN_OFFSET + te);
    s = ke - F;
    if (s > 0) ah = rnd_div(num << s, den, 0);
    else ah = rnd_div(num, den, -s);
    if (ah > AH_MAX) ah = AH_MAX;

    // equivalent rh at the internal temperature
    num = rhe * longint'(KELVIN_OFFSET + ti) * me;
    den = longint'(KELVIN_OFFSET + te) * mi;
    s = ke - ki;
    if (num == 0) begin
      eq = 0;
    end else if (s > 0) begin
      if (s >= 62 || num > ((64'd1 << 62) >> s)) eq = EQ_RH_MAX + 1;
      else eq = rnd_div(num << s, den, 0);
    end else begin
      eq = rnd_div(num, den, -s);
    end
    if (eq > EQ_RH_MAX) begin
      eq = EQ_RH_MAX;
      res.sat = 1'b1;
    end
    diff = longint'(rhi) - longint'(eq);
    res.abs_hum = ah[17:0];
    res.eq_rh = eq[16:0];
    res.diff = diff[17:0];
    return res;
  endfunction

  assign pending = humidity_q.size();

  // predict on input word, compare on output word
  always @(posedge clk) begin
    humidity_word_t exp_w;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        humidity_q.push_back(predict_humidity(internal_temp, internal_rh,
                                              external_temp, external_rh));
      if (out_valid && out_ready) begin
        if (humidity_q.size() == 0) begin
          $display("%0t: unexpected output word abs=%0d eq=%0d", $time,
                   external_abs_humidity, equivalent_rh);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = humidity_q.pop_front();
          if (exp_w.abs_hum !== external_abs_humidity || exp_w.eq_rh !== equivalent_rh ||
              exp_w.diff !== rh_difference || exp_w.sat !== saturated) begin
            $display("%0t: mismatch expected abs=%0d eq=%0d diff=%0d sat=%0d", $time,
                     exp_w.abs_hum, exp_w.eq_rh, $signed(exp_w.diff), exp_w.sat);
            $display("%0t:          actual   abs=%0d eq=%0d diff=%0d sat=%0d", $time,
                     external_abs_humidity, equivalent_rh, rh_difference, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/equivalent_humidity_calc_tb.sv =====
// equivalent_humidity_calc_tb: stimulus, receiver stalls and verdict for the humidity block
`timescale 1ns / 1ps
module equivalent_humidity_calc_tb;
  localparam int RANDOM_WORDS = 1630;
  localparam int QUIET_FROM   = 1450;
  localparam int WATCH_LIMIT  = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [14:0] internal_temp = '0;
  logic        [13:0] internal_rh = '0;
  logic signed [14:0] external_temp = '0;
  logic        [13:0] external_rh = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [17:0] external_abs_humidity;
  logic        [16:0] equivalent_rh;
  logic signed [17:0] rh_difference;
  logic               saturated;
  int                 fail_count;
  int                 pending;
  int                 words_sent = 0;
  int                 idle_cycles = 0;

  always #5 clk = ~clk;

  equivalent_humidity_calc u_dut (.*);
  ehc_checker u_chk (.*);

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_sent > 300) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (words_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("equivalent_humidity_calc regression: fail");
      $finish;
    end
  end

  task automatic send_word(logic signed [14:0] ti, logic [13:0] rhi,
                           logic signed [14:0] te, logic [13:0] rhe);
    if (words_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    internal_temp <= ti;
    internal_rh <= rhi;
    external_temp <= te;
    external_rh <= rhe;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [14:0] pick_temp();
    if ($urandom_range(0, 9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(0, 16500)) - 4000);
  endfunction

  function automatic logic [13:0] pick_rh();
    if ($urandom_range(0, 9) == 0) return 14'($urandom);
    return 14'($urandom_range(0, 10000));
  endfunction

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // field extremes, zero external rh, saturation of equivalent rh
    send_word(0, 0, 0, 0);
    send_word(-15'sd4000, 10000, 12500, 10000);
    send_word(12500, 10000, -15'sd4000, 10000);
    send_word(-15'sd16384, 16383, 16383, 16383);
    send_word(16383, 0, -15'sd16384, 16383);
    send_word(-15'sd16384, 0, -15'sd16384, 16383);
    send_word(16383, 16383, 16383, 16383);
    send_word(2500, 5000, 2500, 0);
    send_word(2500, 5000, 2500, 5000);
    send_word(-15'sd1, 1, 1, 1);
    send_word(0, 10000, 9000, 10000);
    send_word(-15'sd2000, 4000, 3000, 8000);
    send_word(12500, 0, 12500, 10000);
    send_word(-15'sd4000, 0, -15'sd4000, 10000);
    send_word(2000, 16383, 3500, 6000);
    send_word(-15'sd16384, 8000, 12500, 1);
    send_word(10000, 100, -15'sd3000, 9000);
    send_word(3000, 5000, -15'sd16384, 0);
    for (int i = 0; i < RANDOM_WORDS; i++)
      send_word(pick_temp(), pick_rh(), pick_temp(), pick_rh());
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("equivalent_humidity_calc regression: pass");
    end else begin
      $display("equivalent_humidity_calc regression: fail");
    end
    $finish;
  end

endmodule
